// ===== rtl/core/timed_task_table_core_macros.svh =====
// assertion helpers shared by the core
`ifndef TIMED_TASK_TABLE_CORE_MACROS_SVH
`define TIMED_TASK_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define TTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ttt_pkg.sv =====
`default_nettype none

package ttt_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_CANCEL = 2'd2,
    OP_HALT   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_FIRED  = 3'd0,
    KIND_DONE   = 3'd1,
    KIND_ADDED  = 3'd2,
    KIND_FULL   = 3'd3,
    KIND_CANCEL = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now;
    logic [31:0] delay;
    logic        repeat_req;
    logic [15:0] task_tag;
    logic [3:0]  slot;
  } task_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] task_tag_res;
    logic [3:0]  slot_res;
    logic        last;
  } task_res_t;

  // broadcast commands from the controller to every cell
  typedef struct packed {
    logic clear;
    logic arm_all;
    logic add;
  } ttt_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/ttt_cell.sv =====
`default_nettype none

module ttt_cell import ttt_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ttt_cmd_t             cmd,
  input  wire logic                 cancel_hit,
  input  wire logic                 tok_in,
  output logic                      tok,
  input  wire logic                 free_in,
  output logic                      free_out,
  output logic                      claim,
  input  wire logic [TIME_BITS-1:0] scan_now,
  input  wire logic [TIME_BITS-1:0] add_now,
  input  wire logic [TIME_BITS-1:0] add_delay,
  input  wire logic                 add_repeat,
  input  wire logic [15:0]          add_tag,
  output logic                      fire,
  output logic [15:0]               rd_tag
);

  logic                 used;
  logic                 armed;
  logic                 cancelled;
  logic                 periodic;
  logic [TIME_BITS-1:0] due;
  logic [TIME_BITS-1:0] period;
  logic [15:0]          tag;

  logic                 due_hit;
  logic                 add_periodic;
  logic [TIME_BITS:0]   add_sum;
  logic [TIME_BITS:0]   redue_sum;
  logic [TIME_BITS-1:0] add_due;
  logic [TIME_BITS-1:0] redue;

  // lowest free slot wins: a free cell below blocks the claim
  assign free_out = free_in | ~used;
  assign claim    = cmd.add & ~used & ~free_in;

  assign due_hit = used & armed & (due < scan_now);
  assign fire    = tok & due_hit & ~cancelled;

  assign add_periodic = add_repeat & (add_delay != '0);

  // saturating adds
  assign add_sum   = {1'b0, add_now} + {1'b0, add_delay};
  assign redue_sum = {1'b0, due} + {1'b0, period};
  assign add_due   = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];
  assign redue     = redue_sum[TIME_BITS] ? '1 : redue_sum[TIME_BITS-1:0];

  assign rd_tag = (fire | (cancel_hit & used)) ? tag : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok       <= 1'b0;
      used      <= 1'b0;
      armed     <= 1'b0;
      cancelled <= 1'b0;
      periodic  <= 1'b0;
    end else begin
      tok <= tok_in;
      if (cmd.clear) begin
        used      <= 1'b0;
        armed     <= 1'b0;
        cancelled <= 1'b0;
        periodic  <= 1'b0;
      end else if (claim) begin
        used      <= 1'b1;
        armed     <= 1'b0;
        cancelled <= 1'b0;
        periodic  <= add_periodic;
      end else if (cmd.arm_all) begin
        armed <= used;
      end else if (tok & due_hit) begin
        armed <= 1'b0;
        if (cancelled | ~periodic) begin
          used <= 1'b0;
        end
      end else if (cancel_hit & used) begin
        cancelled <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      due    <= add_due;
      period <= add_periodic ? add_delay : '0;
      tag    <= add_tag;
    end else if (fire & periodic) begin
      due <= redue;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/timed_task_table_core.sv =====
// channel   | signals                 | transfer when
// ----------+-------------------------+-------------------------------
// request   | start, busy, req        | rising edge with start & !busy
// result    | strobe, res             | every edge that ends a strobe cycle
//
// add, cancel and cancel-all answer in the cycle after the transfer, busy stays low
// a tick holds busy while the scan token walks the row of cells one slot per cycle,
// then while a closing state arms pending entries and sends tick done
// a tick while halted just clears the table and sends tick done
// reset (rst, synchronous) empties the table and clears halted
// the receiver cannot stall: each result is on the ports for one cycle
`default_nettype none
`include "timed_task_table_core_macros.svh"

module timed_task_table_core import ttt_pkg::*; #(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire task_req_t req,
  output logic           strobe,
  output task_res_t      res
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic                 halted;
  logic                 halted_next;
  logic [IDX_W-1:0]     scan_idx;
  logic [TIME_BITS-1:0] now_q;

  logic                 accept;
  op_e                  op;
  ttt_cmd_t             cmd;
  logic                 tok_start;
  logic                 cancel_go;

  // per-cell wiring: token and free-slot chains run down the row
  logic [SLOTS:0]       tok_chain;
  logic [SLOTS:0]       free_chain;
  logic [SLOTS-1:0]     tok_v;
  logic [SLOTS-1:0]     cancel_hit;
  logic [SLOTS-1:0]     claim_v;
  logic [SLOTS-1:0]     fire_v;
  logic [15:0]          tag_v [SLOTS];

  logic                 fire_any;
  logic [15:0]          sel_tag;
  logic [IDX_W-1:0]     claim_idx;
  logic                 table_full;

  logic                 strobe_next;
  task_res_t            res_next;

  assign accept    = start & ~busy;
  assign op        = op_e'(req.operation);
  assign busy      = (state != S_IDLE);
  assign cancel_go = accept & (op == OP_CANCEL);
  assign tok_start = accept & (op == OP_TICK) & ~halted;

  // a halted tick and cancel-all both wipe the table
  assign cmd.clear   = accept & (((op == OP_TICK) & halted) | (op == OP_HALT));
  assign cmd.arm_all = (state == S_DONE);
  assign cmd.add     = accept & (op == OP_ADD);

  assign tok_chain[0]  = tok_start;
  assign free_chain[0] = 1'b0;
  assign table_full    = ~free_chain[SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    assign cancel_hit[g] = cancel_go & ({28'd0, req.slot} == 32'(g));

    ttt_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .cancel_hit (cancel_hit[g]),
      .tok_in     (tok_chain[g]),
      .tok        (tok_v[g]),
      .free_in    (free_chain[g]),
      .free_out   (free_chain[g+1]),
      .claim      (claim_v[g]),
      .scan_now   (now_q),
      .add_now    (TIME_BITS'(req.now)),
      .add_delay  (TIME_BITS'(req.delay)),
      .add_repeat (req.repeat_req),
      .add_tag    (req.task_tag),
      .fire       (fire_v[g]),
      .rd_tag     (tag_v[g])
    );

    assign tok_chain[g+1] = tok_v[g];
  end

  // at most one cell drives a tag: the token holder or the cancelled slot
  always_comb begin
    sel_tag   = '0;
    claim_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_tag = sel_tag | tag_v[i];
      if (claim_v[i]) begin
        claim_idx = claim_idx | IDX_W'(i);
      end
    end
  end

  assign fire_any = |fire_v;

  // control and result selection
  always_comb begin
    state_next   = state;
    halted_next  = halted;
    strobe_next  = 1'b0;
    res_next     = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_TICK: begin
              if (halted) begin
                strobe_next   = 1'b1;
                res_next.kind = KIND_DONE;
                res_next.last = 1'b1;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_ADD: begin
              strobe_next           = 1'b1;
              res_next.task_tag_res = req.task_tag;
              res_next.last         = 1'b1;
              if (table_full) begin
                res_next.kind = KIND_FULL;
              end else begin
                res_next.kind     = KIND_ADDED;
                res_next.slot_res = 4'(claim_idx);
              end
            end
            OP_CANCEL: begin
              strobe_next           = 1'b1;
              res_next.kind         = KIND_CANCEL;
              res_next.task_tag_res = sel_tag;
              res_next.slot_res     = req.slot;
              res_next.last         = 1'b1;
            end
            OP_HALT: begin
              halted_next   = 1'b1;
              strobe_next   = 1'b1;
              res_next.kind = KIND_CANCEL;
              res_next.last = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (fire_any) begin
          strobe_next           = 1'b1;
          res_next.kind         = KIND_FIRED;
          res_next.task_tag_res = sel_tag;
          res_next.slot_res     = 4'(scan_idx);
        end
        // last cell holds the token: scan is over after this cycle
        if (tok_v[SLOTS-1]) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        strobe_next   = 1'b1;
        res_next.kind = KIND_DONE;
        res_next.last = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      halted   <= 1'b0;
      strobe   <= 1'b0;
      scan_idx <= '0;
    end else begin
      state  <= state_next;
      halted <= halted_next;
      strobe <= strobe_next;
      if (tok_start) begin
        scan_idx <= '0;
      end else if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res <= res_next;
    if (tok_start) begin
      now_q <= TIME_BITS'(req.now);
    end
  end

  // one scan token at most in the row
  `TTT_ASSERT_NOW(a_one_token, clk, rst, 1'b1, $onehot0(tok_v), "more than one scan token")
  // add, cancel and cancel-all answer in the next cycle with a closing result
  `TTT_ASSERT_NEXT(a_single_answer, clk, rst, accept && (op != OP_TICK), strobe && res.last,
    "single-cycle operation gave no closing result")
  // the closing cycle of a scan sends tick done and frees the block
  `TTT_ASSERT_NEXT(a_tick_done, clk, rst, state == S_DONE,
    strobe && (res.kind == KIND_DONE) && res.last && !busy, "tick did not close")

endmodule

`default_nettype wire
